FILE: hw/rtl/cbc_pkg.sv
// cbc_pkg: shared types and constants of the cartridge bank controller
// used by cartridge_bank_controller and cbc_checker; no dependencies

package cbc_pkg;

  // store sizes as address bits
  localparam int unsigned RomAddrBits = 21;
  localparam int unsigned RamAddrBits = 15;

  // widths of the stream payloads
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned KindW    = 3;

  // RAM writes are open only with this enable byte
  localparam logic [7:0] RamEnableKey = 8'h0A;
  // fill value of the RAM after reset
  localparam logic [7:0] RamFillByte  = 8'hFF;

  // controller kinds
  typedef enum logic [KindW-1:0] {
    KIND_NONE    = 3'd0,
    KIND_MBC1    = 3'd1,
    KIND_MBC2    = 3'd2,
    KIND_MBC3    = 3'd3,
    KIND_MBC5    = 3'd4,
    KIND_UNKNOWN = 3'd5
  } cbc_kind_e;

  // input tdata layout, address in the lowest bits
  typedef struct packed {
    logic        pad;
    logic [20:0] preload_address;
    logic        rd;
    logic        wr;
    logic [7:0]  wr_data;
    logic [15:0] address;
  } cbc_in_t;

endpackage

FILE: hw/rtl/cartridge_bank_controller.sv
// cartridge_bank_controller: banked cartridge ROM/RAM with bank registers
// depends on cbc_pkg; checked by cbc_checker (bound in its own file)
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  s_axis  | in  | tvalid/tready         | tdata: address, wr_data, wr, rd, preload
//          |     |                       | tuser: action (1 = ROM preload)
//  m_axis  | out | tvalid/tready         | tdata: read_data, tuser: read_valid
//  cfg     | in  | cfg_wr_en_i (no wait) | cfg_wr_data_i: controller_kind
//
// one item per cycle while m_axis takes results and no clearing pass runs; each item
// gives one result, through the read stage and then the output register; ROM and RAM each take at
// most one access per item on a synchronous port, registered data; after reset a clearing pass
// fills all 2**RamAddrBits (32768) RAM bytes with 0xFF, with s_axis_tready_o low; config writes are taken throughout
// a stalled m_axis holds the result; the input keeps flowing while a slot is free

module cartridge_bank_controller
  import cbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // controller kind register
  input  logic                cfg_wr_en_i,
  input  logic [KindW-1:0]    cfg_wr_data_i,
  // bus access items
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // low to high: address[15:0], wr_data[23:16], wr[24], rd[25],
  // preload_address[46:26], zero pad[47]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // action
  input  logic                s_axis_tuser_i,
  // results
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // read_data[7:0]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // read_valid
  output logic                m_axis_tuser_o
);

  // ---------------------------------------------------------------------
  // state registers
  logic [KindW-1:0] kind_q;
  logic [8:0]       rom_page_q, rom_page_d;
  logic [7:0]       ram_page_q, ram_page_d;
  logic [7:0]       ram_en_q, ram_en_d;
  logic [7:0]       mode_q, mode_d;

  logic                   clr_busy_q;
  logic [RamAddrBits-1:0] clr_addr_q;

  // read stage and output register
  logic       s1_valid_q;
  logic       s1_rvalid_q;
  logic       s1_is_rom_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_rvalid_q;

  // memories
  logic [7:0] rom_mem [2**RomAddrBits];
  logic [7:0] ram_mem [2**RamAddrBits];
  logic [7:0] rom_rdata_q;
  logic [7:0] ram_rdata_q;

  // ---------------------------------------------------------------------
  // decode of the incoming item
  cbc_in_t in;
  logic    accept;
  logic    s1_adv;
  logic    is_preload;
  logic    in_window;
  logic    is_rom_win;
  logic    is_ram_win;
  logic    bus_wr;
  logic    bus_rd;
  logic    mbc1_mode0;

  assign in         = cbc_in_t'(s_axis_tdata_i);
  assign is_preload = s_axis_tuser_i;
  assign is_rom_win = ~in.address[15];
  // 0xA000-0xBFFF
  assign is_ram_win = (in.address[15:13] == 3'b101);
  assign in_window  = is_rom_win | is_ram_win;
  assign bus_wr     = ~is_preload & in_window & in.wr;
  assign bus_rd     = ~is_preload & in_window & ~in.wr & in.rd;
  assign mbc1_mode0 = (kind_q == KIND_MBC1) && (mode_q == 8'h00);

  // pipeline flow
  assign s1_adv          = s1_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~clr_busy_q & (~s1_valid_q | s1_adv);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // ---------------------------------------------------------------------
  // store addresses, wrapped to the store size
  logic [22:0]            rom_wide;
  logic [22:0]            pre_wide;
  logic [20:0]            ram_wide;
  logic [RomAddrBits-1:0] rom_addr;
  logic [RomAddrBits-1:0] pre_addr;
  logic [RamAddrBits-1:0] ram_addr;

  always_comb begin
    // fixed bank below 0x4000, switched bank above
    if (~in.address[14]) begin
      rom_wide = {9'd0, in.address[13:0]};
    end else begin
      rom_wide = {rom_page_q, in.address[13:0]};
    end
    if (mbc1_mode0) begin
      ram_wide = {8'd0, in.address[12:0]};
    end else begin
      ram_wide = {ram_page_q, in.address[12:0]};
    end
    pre_wide = {2'd0, in.preload_address};
  end

  assign rom_addr = rom_wide[RomAddrBits-1:0];
  assign pre_addr = pre_wide[RomAddrBits-1:0];
  assign ram_addr = ram_wide[RamAddrBits-1:0];

  // ---------------------------------------------------------------------
  // bank register writes
  logic [4:0] low5;
  logic [6:0] low7;

  assign low5 = (in.wr_data[4:0] == 5'd0) ? 5'd1 : in.wr_data[4:0];
  assign low7 = (in.wr_data[6:0] == 7'd0) ? 7'd1 : in.wr_data[6:0];

  always_comb begin
    rom_page_d = rom_page_q;
    ram_page_d = ram_page_q;
    ram_en_d   = ram_en_q;
    mode_d     = mode_q;
    if (accept && bus_wr && is_rom_win) begin
      case (in.address[14:13])
        2'b00: begin
          ram_en_d = in.wr_data;
        end
        2'b01: begin
          // low bank bits, per kind
          if (kind_q == KIND_MBC1) begin
            rom_page_d = {rom_page_q[8:5], low5};
          end else if (kind_q == KIND_MBC3) begin
            rom_page_d = {rom_page_q[8:7], low7};
          end else if (kind_q == KIND_MBC5) begin
            if (~in.address[12]) begin
              rom_page_d = {rom_page_q[8], in.wr_data};
            end else begin
              rom_page_d = {in.wr_data[0], rom_page_q[7:0]};
            end
          end
        end
        2'b10: begin
          // MBC1 mode zero: upper ROM bank bits, bit 7 cleared; otherwise the RAM bank
          if (mbc1_mode0) begin
            rom_page_d = {rom_page_q[8], 1'b0, in.wr_data[1:0], rom_page_q[4:0]};
          end else begin
            ram_page_d = in.wr_data;
          end
        end
        default: begin
          mode_d = in.wr_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= KIND_NONE;
      rom_page_q <= 9'd1;
      ram_page_q <= 8'd0;
      ram_en_q   <= 8'd0;
      mode_q     <= 8'd0;
    end else begin
      if (cfg_wr_en_i) begin
        kind_q <= cfg_wr_data_i;
      end
      rom_page_q <= rom_page_d;
      ram_page_q <= ram_page_d;
      ram_en_q   <= ram_en_d;
      mode_q     <= mode_d;
    end
  end

  // ---------------------------------------------------------------------
  // RAM clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // ROM store: preload writes, bus reads
  logic rom_we;
  logic rom_re;

  assign rom_we = accept & is_preload;
  assign rom_re = accept & bus_rd & is_rom_win;

  always_ff @(posedge clk_i) begin
    if (rom_we) begin
      rom_mem[pre_addr] <= in.wr_data;
    end
    if (rom_re) begin
      rom_rdata_q <= rom_mem[rom_addr];
    end
  end

  // RAM store: clearing pass or enabled bus writes, bus reads
  logic                   ram_we;
  logic                   ram_re;
  logic [RamAddrBits-1:0] ram_waddr;
  logic [7:0]             ram_wdata;

  assign ram_re = accept & bus_rd & is_ram_win;

  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = RamFillByte;
    end else begin
      ram_we    = accept & bus_wr & is_ram_win & (ram_en_q == RamEnableKey);
      ram_waddr = ram_addr;
      ram_wdata = in.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      ram_rdata_q <= ram_mem[ram_addr];
    end
  end

  // ---------------------------------------------------------------------
  // read stage: marks the item whose memory data is on the way
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_rvalid_q <= 1'b0;
      s1_is_rom_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q  <= 1'b1;
      s1_rvalid_q <= bus_rd;
      s1_is_rom_q <= is_rom_win;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // output register
  logic [7:0] s1_data;

  assign s1_data = ~s1_rvalid_q ? 8'd0 : (s1_is_rom_q ? rom_rdata_q : ram_rdata_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_rvalid_q <= 1'b0;
      out_data_q   <= 8'd0;
    end else if (s1_adv) begin
      out_valid_q  <= 1'b1;
      out_rvalid_q <= s1_rvalid_q;
      out_data_q   <= s1_data;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_rvalid_q;

endmodule

FILE: hw/rtl/cbc_checker.sv
// cbc_checker: port-level checks of cartridge_bank_controller over time
// depends on cbc_pkg; attached to cartridge_bank_controller by the bind at the end

module cbc_checker
  import cbc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tuser_o
);

  // no input transfer while in reset or right after it (RAM clearing)
  a_no_accept_after_reset: assert property (
    @(posedge clk_i) !rst_ni |=> !s_axis_tready_o
  ) else $error("input ready during or right after reset");

  // a result that carries no read is all zeros
  a_zero_when_no_read: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0
  ) else $error("non-read result with nonzero data");

  // a fresh result follows an input transfer, through the read stage and the output register
  a_result_has_source: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2)
  ) else $error("result without a matching input transfer");

  // a stalled result holds
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
  ) else $error("stalled result changed");

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
